### hdl/cuvm_pkg.sv
// Shared types, constants and the CORDIC angle table of the cylindrical UV mapper.
package cuvm_pkg;

    // Field and arithmetic widths fixed by the data formats.
    localparam int COORD_W   = 24;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W - 1;
    localparam int TEX_W     = 16;
    localparam int ANG_W     = 32;
    localparam int ACC_W     = ANG_W + 3;
    localparam int TABLE_LEN = 24;

    // Default values of the top-level parameters.
    localparam int DEF_CORDIC_STAGES   = 16;
    localparam int DEF_COORD_FRAC_BITS = 16;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 3;
    typedef logic [CFG_INDEX_W-1:0] t_cfg_index;

    localparam t_cfg_index CFG_CENTER_X    = 3'd0;
    localparam t_cfg_index CFG_CENTER_Y    = 3'd1;
    localparam t_cfg_index CFG_CENTER_Z    = 3'd2;
    localparam t_cfg_index CFG_INV_RANGE_X = 3'd3;
    localparam t_cfg_index CFG_INV_RANGE_Y = 3'd4;
    localparam t_cfg_index CFG_INV_RANGE_Z = 3'd5;

    // Register values after reset.
    localparam logic [COORD_W-1:0] RST_CENTER_X  = 24'hFFF807;
    localparam logic [COORD_W-1:0] RST_CENTER_Y  = 24'h010E46;
    localparam logic [COORD_W-1:0] RST_CENTER_Z  = 24'hFF8390;
    localparam logic [COORD_W-1:0] RST_INV_RANGE = 24'h008000;

    // One vertex beat.
    typedef struct packed {
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
    } t_vertex;

    // One texture coordinate beat.
    typedef struct packed {
        logic [TEX_W-1:0] tex_u;
        logic [TEX_W-1:0] tex_v;
    } t_texel;

    // atan(2^-i) / (2 pi) in unsigned Q0.32 turns.
    function automatic logic [ANG_W-1:0] turn_angle(input int idx);
        logic [ANG_W-1:0] ang;
        case (idx)
            0:       ang = 32'h20000000;
            1:       ang = 32'h12E4051E;
            2:       ang = 32'h09FB385B;
            3:       ang = 32'h051111D4;
            4:       ang = 32'h028B0D43;
            5:       ang = 32'h0145D7E1;
            6:       ang = 32'h00A2F61E;
            7:       ang = 32'h00517C55;
            8:       ang = 32'h0028BE53;
            9:       ang = 32'h00145F2F;
            10:      ang = 32'h000A2F98;
            11:      ang = 32'h000517CC;
            12:      ang = 32'h00028BE6;
            13:      ang = 32'h000145F3;
            14:      ang = 32'h0000A2F9;
            15:      ang = 32'h0000517C;
            16:      ang = 32'h000028BE;
            17:      ang = 32'h0000145F;
            18:      ang = 32'h00000A2F;
            19:      ang = 32'h00000517;
            20:      ang = 32'h0000028B;
            21:      ang = 32'h00000145;
            22:      ang = 32'h000000A2;
            23:      ang = 32'h00000051;
            default: ang = '0;
        endcase
        return ang;
    endfunction

endpackage

### hdl/cylindrical_uv_mapper.sv
// Top level of the cylindrical UV mapper: registers, pipeline and CORDIC chain.
//
//   channel   direction  handshake            payload
//   vertex    in         i_valid / o_stall    i_vertex (t_vertex)
//   texel     out        o_valid / i_stall    o_texel  (t_texel)
//   config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
// One vertex is taken every cycle while o_stall is low; each beat passes
// through two normalize stages, one setup stage, one cell per CORDIC stage
// (at most TABLE_LEN cells) and the output register.
// Reset is synchronous and loads the register defaults; there is no
// clearing pass. Empty stages close up under a stall, so o_stall rises only
// when every stage holds a beat and the output is stalled.
module cylindrical_uv_mapper #(
    parameter int CORDIC_STAGES   = cuvm_pkg::DEF_CORDIC_STAGES,
    parameter int COORD_FRAC_BITS = cuvm_pkg::DEF_COORD_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  cuvm_pkg::t_vertex             i_vertex,
    output logic                          o_valid,
    input  logic                          i_stall,
    output cuvm_pkg::t_texel              o_texel,
    input  logic                          i_cfg_we,
    input  cuvm_pkg::t_cfg_index          i_cfg_index,
    input  logic [cuvm_pkg::COORD_W-1:0]  i_cfg_data
);
    import cuvm_pkg::*;

    localparam int NW    = PROD_W - COORD_FRAC_BITS;
    localparam int CW    = NW + 3;
    localparam int TW    = NW + 9;
    localparam int SH    = COORD_FRAC_BITS + 1 - TEX_W;
    localparam int NCELL = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

    localparam logic signed [ACC_W-1:0] HALF_TURN = ACC_W'(64'sd1 <<< (ANG_W - 1));
    localparam logic signed [TW-1:0]    ONE_T     = TW'(64'sd1 <<< COORD_FRAC_BITS);

    // Configuration registers.
    logic [COORD_W-1:0] r_center_x, r_center_y, r_center_z;
    logic [COORD_W-1:0] r_inv_x, r_inv_y, r_inv_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= RST_CENTER_X;
            r_center_y <= RST_CENTER_Y;
            r_center_z <= RST_CENTER_Z;
            r_inv_x    <= RST_INV_RANGE;
            r_inv_y    <= RST_INV_RANGE;
            r_inv_z    <= RST_INV_RANGE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CENTER_X:    r_center_x <= i_cfg_data;
                CFG_CENTER_Y:    r_center_y <= i_cfg_data;
                CFG_CENTER_Z:    r_center_z <= i_cfg_data;
                CFG_INV_RANGE_X: r_inv_x    <= i_cfg_data;
                CFG_INV_RANGE_Y: r_inv_y    <= i_cfg_data;
                CFG_INV_RANGE_Z: r_inv_z    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Centering and scaling.
    logic                 norm_vld;
    logic                 norm_rdy;
    logic                 norm_in_rdy;
    logic signed [NW-1:0] nx, ny, nz;

    cuvm_norm #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_norm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (i_valid),
        .o_rdy      (norm_in_rdy),
        .i_vertex   (i_vertex),
        .i_center_x (r_center_x),
        .i_center_y (r_center_y),
        .i_center_z (r_center_z),
        .i_inv_x    (r_inv_x),
        .i_inv_y    (r_inv_y),
        .i_inv_z    (r_inv_z),
        .o_vld      (norm_vld),
        .i_rdy      (norm_rdy),
        .o_nx       (nx),
        .o_ny       (ny),
        .o_nz       (nz)
    );

    assign o_stall = !norm_in_rdy;

    // Setup stage: fold the left half plane over and form v.
    logic                    r_p_vld;
    logic signed [CW-1:0]    r_p_x, r_p_y;
    logic signed [ACC_W-1:0] r_p_acc;
    logic                    r_p_zero;
    logic [TEX_W-1:0]        r_p_v;
    logic                    p_rdy;
    logic signed [CW-1:0]    n_p_x, n_p_y;
    logic signed [ACC_W-1:0] n_p_acc;
    logic [TEX_W-1:0]        n_p_v;
    logic signed [TW-1:0]    w_t;
    logic signed [TW-1:0]    w_r;

    always_comb begin
        if (nx[NW-1]) begin
            n_p_x   = -CW'(nx);
            n_p_y   = -CW'(nz);
            n_p_acc = nz[NW-1] ? -HALF_TURN : HALF_TURN;
        end else begin
            n_p_x   = CW'(nx);
            n_p_y   = CW'(nz);
            n_p_acc = '0;
        end
    end

    assign w_t = TW'(ny) + ONE_T;

    generate
        if (SH >= 0) begin : g_v_right
            assign w_r = w_t >>> SH;
        end else begin : g_v_left
            assign w_r = w_t <<< (-SH);
        end
    endgenerate

    // Saturate v to the unsigned output range.
    always_comb begin
        if (w_r[TW-1]) begin
            n_p_v = '0;
        end else if (|w_r[TW-2:TEX_W]) begin
            n_p_v = '1;
        end else begin
            n_p_v = w_r[TEX_W-1:0];
        end
    end

    // Cell chain links; link zero is fed by the setup stage.
    logic                    c_vld  [NCELL+1];
    logic                    c_rdy  [NCELL+1];
    logic signed [CW-1:0]    c_x    [NCELL+1];
    logic signed [CW-1:0]    c_y    [NCELL+1];
    logic signed [ACC_W-1:0] c_acc  [NCELL+1];
    logic                    c_zero [NCELL+1];
    logic [TEX_W-1:0]        c_v    [NCELL+1];

    assign p_rdy    = !r_p_vld || c_rdy[0];
    assign norm_rdy = p_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (p_rdy) begin
            r_p_vld <= norm_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_rdy && norm_vld) begin
            r_p_x    <= n_p_x;
            r_p_y    <= n_p_y;
            r_p_acc  <= n_p_acc;
            r_p_zero <= (nx == '0) && (nz == '0);
            r_p_v    <= n_p_v;
        end
    end

    assign c_vld[0]  = r_p_vld;
    assign c_x[0]    = r_p_x;
    assign c_y[0]    = r_p_y;
    assign c_acc[0]  = r_p_acc;
    assign c_zero[0] = r_p_zero;
    assign c_v[0]    = r_p_v;

    // One CORDIC cell per stage, at most TABLE_LEN cells.
    generate
        for (genvar gi = 0; gi < NCELL; gi++) begin : g_cell
            cuvm_cell #(
                .IDX (gi),
                .CW  (CW)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_vld   (c_vld[gi]),
                .o_rdy   (c_rdy[gi]),
                .i_x     (c_x[gi]),
                .i_y     (c_y[gi]),
                .i_acc   (c_acc[gi]),
                .i_zero  (c_zero[gi]),
                .i_v     (c_v[gi]),
                .o_vld   (c_vld[gi+1]),
                .i_rdy   (c_rdy[gi+1]),
                .o_x     (c_x[gi+1]),
                .o_y     (c_y[gi+1]),
                .o_acc   (c_acc[gi+1]),
                .o_zero  (c_zero[gi+1]),
                .o_v     (c_v[gi+1])
            );
        end
    endgenerate

    // Output stage: shift the angle into [0, 1) turns and saturate u; a zero radius gives u of one half.
    logic                    r_o_vld;
    t_texel                  r_texel;
    logic                    o_rdy;
    logic signed [ACC_W-1:0] w_a;
    logic [TEX_W-1:0]        n_u;

    assign o_rdy          = !r_o_vld || !i_stall;
    assign c_rdy[NCELL]   = o_rdy;
    assign w_a            = c_acc[NCELL] + HALF_TURN;

    always_comb begin
        if (c_zero[NCELL]) begin
            n_u = TEX_W'(1) << (TEX_W - 1);
        end else if (w_a[ACC_W-1]) begin
            n_u = '0;
        end else if (|w_a[ACC_W-2:ANG_W]) begin
            n_u = '1;
        end else begin
            n_u = w_a[ANG_W-1:ANG_W-TEX_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (o_rdy) begin
            r_o_vld <= c_vld[NCELL];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && c_vld[NCELL]) begin
            r_texel.tex_u <= n_u;
            r_texel.tex_v <= c_v[NCELL];
        end
    end

    assign o_valid = r_o_vld;
    assign o_texel = r_texel;

endmodule

### hdl/cuvm_norm.sv
// Two-stage centering and scaling of the three vertex coordinates.
module cuvm_norm #(
    parameter int COORD_FRAC_BITS = cuvm_pkg::DEF_COORD_FRAC_BITS
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_vld,
    output logic                                    o_rdy,
    input  cuvm_pkg::t_vertex                       i_vertex,
    input  logic [cuvm_pkg::COORD_W-1:0]            i_center_x,
    input  logic [cuvm_pkg::COORD_W-1:0]            i_center_y,
    input  logic [cuvm_pkg::COORD_W-1:0]            i_center_z,
    input  logic [cuvm_pkg::COORD_W-1:0]            i_inv_x,
    input  logic [cuvm_pkg::COORD_W-1:0]            i_inv_y,
    input  logic [cuvm_pkg::COORD_W-1:0]            i_inv_z,
    output logic                                    o_vld,
    input  logic                                    i_rdy,
    output logic signed [cuvm_pkg::PROD_W-COORD_FRAC_BITS-1:0] o_nx,
    output logic signed [cuvm_pkg::PROD_W-COORD_FRAC_BITS-1:0] o_ny,
    output logic signed [cuvm_pkg::PROD_W-COORD_FRAC_BITS-1:0] o_nz
);
    import cuvm_pkg::*;

    logic                     r_s1_vld;
    logic                     r_s2_vld;
    logic                     s1_rdy;
    logic                     s2_rdy;
    logic signed [DIFF_W-1:0] r_dx, r_dy, r_dz;
    logic signed [PROD_W-1:0] r_px, r_py, r_pz;
    logic signed [PROD_W-1:0] n_px, n_py, n_pz;

    // Each stage takes a beat when it is empty or its own beat moves on.
    assign s2_rdy = !r_s2_vld || i_rdy;
    assign s1_rdy = !r_s1_vld || s2_rdy;
    assign o_rdy  = s1_rdy;
    assign o_vld  = r_s2_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            if (s1_rdy) begin
                r_s1_vld <= i_vld;
            end
            if (s2_rdy) begin
                r_s2_vld <= r_s1_vld;
            end
        end
    end

    // Stage one: subtract the midpoint of each axis.
    always_ff @(posedge i_clk) begin
        if (s1_rdy && i_vld) begin
            r_dx <= DIFF_W'(i_vertex.coord_x) - DIFF_W'($signed(i_center_x));
            r_dy <= DIFF_W'(i_vertex.coord_y) - DIFF_W'($signed(i_center_y));
            r_dz <= DIFF_W'(i_vertex.coord_z) - DIFF_W'($signed(i_center_z));
        end
    end

    // Stage two: scale by the unsigned reciprocal range.
    assign n_px = PROD_W'(r_dx) * PROD_W'($signed({1'b0, i_inv_x}));
    assign n_py = PROD_W'(r_dy) * PROD_W'($signed({1'b0, i_inv_y}));
    assign n_pz = PROD_W'(r_dz) * PROD_W'($signed({1'b0, i_inv_z}));

    always_ff @(posedge i_clk) begin
        if (s2_rdy && r_s1_vld) begin
            r_px <= n_px;
            r_py <= n_py;
            r_pz <= n_pz;
        end
    end

    // Dropping the low fraction bits is a floor shift.
    assign o_nx = r_px[PROD_W-1:COORD_FRAC_BITS];
    assign o_ny = r_py[PROD_W-1:COORD_FRAC_BITS];
    assign o_nz = r_pz[PROD_W-1:COORD_FRAC_BITS];

endmodule

### hdl/cuvm_cell.sv
// One vectoring CORDIC cell: a single micro-rotation with its angle step.
module cuvm_cell #(
    parameter int IDX = 0,
    parameter int CW  = 36
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_vld,
    output logic                                 o_rdy,
    input  logic signed [CW-1:0]                 i_x,
    input  logic signed [CW-1:0]                 i_y,
    input  logic signed [cuvm_pkg::ACC_W-1:0]    i_acc,
    input  logic                                 i_zero,
    input  logic [cuvm_pkg::TEX_W-1:0]           i_v,
    output logic                                 o_vld,
    input  logic                                 i_rdy,
    output logic signed [CW-1:0]                 o_x,
    output logic signed [CW-1:0]                 o_y,
    output logic signed [cuvm_pkg::ACC_W-1:0]    o_acc,
    output logic                                 o_zero,
    output logic [cuvm_pkg::TEX_W-1:0]           o_v
);
    import cuvm_pkg::*;

    localparam logic signed [ACC_W-1:0] ANG = ACC_W'(turn_angle(IDX));

    logic                    r_vld;
    logic signed [CW-1:0]    r_x, r_y;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_zero;
    logic [TEX_W-1:0]        r_v;
    logic signed [CW-1:0]    xs, ys;
    logic signed [CW-1:0]    n_x, n_y;
    logic signed [ACC_W-1:0] n_acc;

    assign o_rdy = !r_vld || i_rdy;

    // Rotate toward the x axis; the residual sign picks the direction.
    assign xs = i_x >>> IDX;
    assign ys = i_y >>> IDX;

    always_comb begin
        if (!i_y[CW-1]) begin
            n_x   = i_x + ys;
            n_y   = i_y - xs;
            n_acc = i_acc + ANG;
        end else begin
            n_x   = i_x - ys;
            n_y   = i_y + xs;
            n_acc = i_acc - ANG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_acc  <= n_acc;
            r_zero <= i_zero;
            r_v    <= i_v;
        end
    end

    assign o_vld  = r_vld;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_acc  = r_acc;
    assign o_zero = r_zero;
    assign o_v    = r_v;

endmodule
